@@ rtl/i2cram_pkg.sv @@
// Package for the I2C register access master: payload words, phase codes,
// command codes and sizing constants. No dependencies.
`default_nettype none

package i2cram_pkg;

  // Longest burst read, in bytes
  localparam int MAX_BURST = 16;
  localparam int BL_W      = $clog2(MAX_BURST + 1);

  // Reset value of the device address register
  localparam logic [6:0] DEV_ADDR_RESET = 7'd50;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register index
  localparam logic REG_DEV_ADDR = 1'b0;

  // Half-bit bus phases
  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_START_C,
    PH_RESTART, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW,
    PH_ACK_HIGH, PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW,
    PH_MACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_e;

  // Which byte is on the wire
  typedef enum logic [1:0] {
    STG_WADDR, STG_REG, STG_VALUE, STG_RADDR
  } stage_e;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] reg_address;
    logic [7:0] write_value;
    logic [4:0] read_count;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       busy_res;
    logic       done_res;
  } out_word_t;

  typedef struct packed {
    phase_e          phase;
    logic [3:0]      bit_index;
    logic [7:0]      shift_reg;
    logic [BL_W-1:0] bytes_left;
    logic [1:0]      latched_command;
    logic [3:0]      latched_register;
    logic [7:0]      latched_value;
    stage_e          byte_stage;
  } core_state_t;

endpackage

`default_nettype wire

@@ rtl/i2cram_phase_logic.sv @@
// One bus phase step: from the current sequencer state, the tick word and
// the device address, the next state and the result word. Uses i2cram_pkg.
`default_nettype none

module i2cram_phase_logic (
  input  i2cram_pkg::core_state_t state_i,
  input  i2cram_pkg::in_word_t    in_i,
  input  logic [6:0]              dev_addr_i,
  output i2cram_pkg::core_state_t state_o,
  output i2cram_pkg::out_word_t   res_o
);
  import i2cram_pkg::*;

  core_state_t     cur;
  logic [BL_W-1:0] cnt;
  logic [3:0]      bit_inc;
  logic [7:0]      rx_shift;

  // Burst length, zero taken as one and clipped to the longest burst
  always_comb begin
    if (32'(in_i.read_count) > 32'(MAX_BURST)) begin
      cnt = BL_W'(MAX_BURST);
    end else if (in_i.read_count == 5'd0) begin
      cnt = BL_W'(1);
    end else begin
      cnt = BL_W'(in_i.read_count);
    end
  end

  // A command in idle latches its operands and starts on this same tick
  always_comb begin
    cur = state_i;
    if (state_i.phase == PH_IDLE &&
        (in_i.command == CMD_WRITE || in_i.command == CMD_READ)) begin
      cur.latched_command  = in_i.command;
      cur.latched_register = in_i.reg_address;
      cur.latched_value    = in_i.write_value;
      cur.bytes_left       = cnt;
      cur.byte_stage       = STG_WADDR;
      cur.bit_index        = 4'd0;
      cur.phase            = PH_START_A;
    end
  end

  assign bit_inc  = cur.bit_index + 4'd1;
  assign rx_shift = {cur.shift_reg[6:0], in_i.sda_in};

  // Next state
  always_comb begin
    state_o = cur;
    case (cur.phase)
      PH_START_A: state_o.phase = PH_START_B;
      PH_START_B: state_o.phase = PH_START_C;
      PH_START_C: begin
        state_o.shift_reg = {dev_addr_i, cur.byte_stage == STG_RADDR};
        state_o.bit_index = 4'd0;
        state_o.phase     = PH_TX_LOW;
      end
      PH_RESTART: begin
        state_o.byte_stage = STG_RADDR;
        state_o.phase      = PH_START_A;
      end
      PH_TX_LOW: state_o.phase = PH_TX_HIGH;
      PH_TX_HIGH: begin
        state_o.shift_reg = {cur.shift_reg[6:0], 1'b0};
        state_o.bit_index = bit_inc;
        state_o.phase     = bit_inc[3] ? PH_ACK_LOW : PH_TX_LOW;
      end
      PH_ACK_LOW: state_o.phase = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        state_o.bit_index = 4'd0;
        case (cur.byte_stage)
          STG_WADDR: begin
            state_o.shift_reg  = {cur.latched_register, 3'b000,
                                  cur.latched_command == CMD_READ};
            state_o.byte_stage = STG_REG;
            state_o.phase      = PH_TX_LOW;
          end
          STG_REG: begin
            if (cur.latched_command == CMD_READ) begin
              state_o.phase = PH_RESTART;
            end else begin
              state_o.shift_reg  = cur.latched_value;
              state_o.byte_stage = STG_VALUE;
              state_o.phase      = PH_TX_LOW;
            end
          end
          STG_VALUE: state_o.phase = PH_STOP_A;
          default: begin
            state_o.shift_reg = 8'd0;
            state_o.phase     = PH_RX_LOW;
          end
        endcase
      end
      PH_RX_LOW: state_o.phase = PH_RX_HIGH;
      PH_RX_HIGH: begin
        state_o.shift_reg = rx_shift;
        state_o.bit_index = bit_inc;
        state_o.phase     = bit_inc[3] ? PH_MACK_LOW : PH_RX_LOW;
      end
      PH_MACK_LOW: state_o.phase = PH_MACK_HIGH;
      PH_MACK_HIGH: begin
        state_o.bit_index = 4'd0;
        state_o.shift_reg = 8'd0;
        if (cur.bytes_left > BL_W'(1)) begin
          state_o.bytes_left = cur.bytes_left - BL_W'(1);
          state_o.phase      = PH_RX_LOW;
        end else begin
          state_o.bytes_left = '0;
          state_o.phase      = PH_STOP_A;
        end
      end
      PH_STOP_A: state_o.phase = PH_STOP_B;
      PH_STOP_B: state_o.phase = PH_STOP_C;
      PH_STOP_C: state_o.phase = PH_IDLE;
      default:   state_o.phase = PH_IDLE;
    endcase
  end

  // Bus levels and status for this phase
  always_comb begin
    res_o              = '0;
    res_o.scl_level    = 1'b1;
    res_o.sda_pull_low = 1'b0;
    case (cur.phase)
      PH_START_A: ;
      PH_START_B: res_o.sda_pull_low = 1'b1;
      PH_START_C: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = 1'b1;
      end
      PH_RESTART: res_o.scl_level = 1'b0;
      PH_TX_LOW: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = ~cur.shift_reg[7];
      end
      PH_TX_HIGH: res_o.sda_pull_low = ~cur.shift_reg[7];
      PH_ACK_LOW: res_o.scl_level = 1'b0;
      PH_ACK_HIGH: ;
      PH_RX_LOW: res_o.scl_level = 1'b0;
      PH_RX_HIGH: begin
        if (bit_inc[3]) begin
          res_o.read_byte  = rx_shift;
          res_o.byte_valid = 1'b1;
        end
      end
      // Acknowledge every byte but the last
      PH_MACK_LOW: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = cur.bytes_left > BL_W'(1);
      end
      PH_MACK_HIGH: res_o.sda_pull_low = cur.bytes_left > BL_W'(1);
      PH_STOP_A: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = 1'b1;
      end
      PH_STOP_B: res_o.sda_pull_low = 1'b1;
      PH_STOP_C: res_o.done_res = 1'b1;
      default: ;
    endcase
    res_o.busy_res = state_o.phase != PH_IDLE;
  end

endmodule

`default_nettype wire

@@ rtl/i2c_register_access_master_core.sv @@
// Top level of the I2C register access master: sequencer state, result
// register, APB register port. Uses i2cram_pkg and i2cram_phase_logic.
`default_nettype none

// Each input word is one half-bit bus tick from an external clock divider;
// each accepted word yields exactly one result word with the SCL level, the
// SDA pull-down, any received byte and busy/done status. The block takes one
// word per cycle: the phase step is a single pass of logic from the state
// registers into one output register, and a word is accepted whenever that
// register is empty or being taken. A result is registered as its word is
// accepted. A register write takes 60 ticks (start 3, three bytes of
// 18 each with the acknowledge, stop 3); a burst read of n bytes takes
// 64+18*n ticks (two address bytes, repeated start, read address, n bytes with
// master acknowledge, stop). Commands arriving while busy are ignored. Write
// device_address (APB offset 0) only while idle.
module i2c_register_access_master_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cram_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cram_pkg::out_word_t out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import i2cram_pkg::*;

  core_state_t state_q, state_d;
  out_word_t   res, out_data_q;
  logic        out_valid_q;
  logic [6:0]  dev_addr_q;
  logic        in_accept;
  logic        cfg_we;

  // Handshake: the output register parts the two sides
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_DEV_ADDR);
  assign prdata = (paddr[2] == REG_DEV_ADDR) ? {25'd0, dev_addr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RESET;
    end else if (cfg_we) begin
      dev_addr_q <= pwdata[6:0];
    end
  end

  i2cram_phase_logic u_phase (
    .state_i    (state_q),
    .in_i       (in_data_i),
    .dev_addr_i (dev_addr_q),
    .state_o    (state_d),
    .res_o      (res)
  );

  // Sequencer state; all zero is idle, first byte stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Result word valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= res;
    end
  end

  // Checks
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && state_q.phase == PH_IDLE && in_data_i.command != CMD_WRITE &&
    in_data_i.command != CMD_READ |=> state_q.phase == PH_IDLE)
    else $error("idle tick without a command left idle");

  a_byte_to_mack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && res.byte_valid |=> state_q.phase == PH_MACK_LOW &&
    out_valid_q && out_data_q.byte_valid)
    else $error("received byte not followed by master acknowledge");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with an empty result register");

  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.bytes_left) <= 32'(MAX_BURST))
    else $error("burst count beyond its limit");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && res.done_res |=> state_q.phase == PH_IDLE && !out_data_q.busy_res)
    else $error("stop completed but sequencer not idle");

endmodule

`default_nettype wire

@@ tb/sv/tb_i2c_register_access_master_core.sv @@
// Testbench for i2c_register_access_master_core: a directed table, then random register
// transactions, checked word by word against an in-bench bus-phase predictor.
// Depends on i2cram_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_i2c_register_access_master_core;
  import i2cram_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;   // decodes as a plain tick
  localparam int         HOLD_CYCLES = 50;
  localparam int         TAIL_CYCLES = 4;
  localparam int         QUIET_LIMIT = 500;

  localparam out_word_t IDLE_WORD  = '{scl_level: 1'b1, default: '0};
  localparam out_word_t START_WORD = '{scl_level: 1'b1, busy_res: 1'b1, default: '0};

  // SDA level pattern used while a directed transaction runs out
  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_TOGGLE, SDA_RANDOM} sda_pat_e;

  typedef struct packed {
    in_word_t  w;
    sda_pat_e  pat;
    logic      finish;
    logic      fixed;
    out_word_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_word_t    in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_word_t   out_data_o;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [6:0]      dev_addr;
  phase_e          ph;
  logic [3:0]      bidx;
  logic [7:0]      shreg;
  logic [BL_W-1:0] left;
  logic [1:0]      lcmd;
  logic [3:0]      lreg;
  logic [7:0]      lval;
  stage_e          stg;

  out_word_t bus_words_due[$];
  out_word_t due_word;
  dir_row_t  dir_rows[$];
  int        mismatches = 0;
  int        gap_pct    = 0;
  int        stall_pct  = 0;
  logic      hold_req   = 1'b0;
  logic      hold_taken;
  int        hold_left;
  int        quiet;
  logic      toggle_sda = 1'b0;

  i2c_register_access_master_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // One half-bit bus tick of the master
  task automatic advance_bus(input in_word_t w, output out_word_t r);
    int cnt;
    r = IDLE_WORD;
    if (ph == PH_IDLE && (w.command == CMD_WRITE || w.command == CMD_READ)) begin
      cnt = w.read_count;
      if (cnt == 0) cnt = 1;
      if (cnt > MAX_BURST) cnt = MAX_BURST;
      lcmd = w.command;
      lreg = w.reg_address;
      lval = w.write_value;
      left = cnt[BL_W-1:0];
      stg  = STG_WADDR;
      bidx = '0;
      ph   = PH_START_A;
    end
    case (ph)
      PH_START_A: ph = PH_START_B;
      PH_START_B: begin
        r.sda_pull_low = 1'b1;
        ph = PH_START_C;
      end
      PH_START_C: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = 1'b1;
        shreg = {dev_addr, stg == STG_RADDR};
        bidx = '0;
        ph = PH_TX_LOW;
      end
      PH_RESTART: begin
        r.scl_level = 1'b0;
        stg = STG_RADDR;
        ph = PH_START_A;
      end
      PH_TX_LOW: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = ~shreg[7];
        ph = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        r.sda_pull_low = ~shreg[7];
        shreg = shreg << 1;
        bidx = bidx + 4'd1;
        ph = (bidx >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
      end
      PH_ACK_LOW: begin
        r.scl_level = 1'b0;
        ph = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        bidx = '0;
        case (stg)
          STG_WADDR: begin
            shreg = {lreg, 3'b000, lcmd == CMD_READ};
            stg = STG_REG;
            ph = PH_TX_LOW;
          end
          STG_REG: begin
            if (lcmd == CMD_READ) begin
              ph = PH_RESTART;
            end else begin
              shreg = lval;
              stg = STG_VALUE;
              ph = PH_TX_LOW;
            end
          end
          STG_VALUE: ph = PH_STOP_A;
          default: begin
            shreg = '0;
            ph = PH_RX_LOW;
          end
        endcase
      end
      PH_RX_LOW: begin
        r.scl_level = 1'b0;
        ph = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        shreg = {shreg[6:0], w.sda_in};
        bidx = bidx + 4'd1;
        if (bidx >= 4'd8) begin
          r.read_byte = shreg;
          r.byte_valid = 1'b1;
          ph = PH_MACK_LOW;
        end else begin
          ph = PH_RX_LOW;
        end
      end
      PH_MACK_LOW: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = (left > 1);
        ph = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        // ack every byte but the last
        r.sda_pull_low = (left > 1);
        if (left > 0) left = left - 1'b1;
        bidx = '0;
        shreg = '0;
        ph = (left > 0) ? PH_RX_LOW : PH_STOP_A;
      end
      PH_STOP_A: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = 1'b1;
        ph = PH_STOP_B;
      end
      PH_STOP_B: begin
        r.sda_pull_low = 1'b1;
        ph = PH_STOP_C;
      end
      PH_STOP_C: begin
        r.done_res = 1'b1;
        ph = PH_IDLE;
      end
      default: ph = PH_IDLE;
    endcase
    r.busy_res = (ph != PH_IDLE);
  endtask

  // Offer one word, wait for it to be taken, then queue its expected result
  task automatic send_word(input in_word_t w, input logic fixed, input out_word_t want);
    out_word_t r;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    advance_bus(w, r);
    bus_words_due.push_back(fixed ? want : r);
  endtask

  // Tick until the transaction in flight has finished
  task automatic run_out(input sda_pat_e pat);
    in_word_t w;
    while (ph != PH_IDLE) begin
      w = in_word_t'($urandom);
      w.command = CMD_TICK;
      case (pat)
        SDA_LOW:    w.sda_in = 1'b0;
        SDA_HIGH:   w.sda_in = 1'b1;
        SDA_TOGGLE: begin
          toggle_sda = ~toggle_sda;
          w.sda_in = toggle_sda;
        end
        default:    w.sda_in = 1'($urandom);
      endcase
      send_word(w, 1'b0, '0);
    end
  endtask

  // Stop offering words until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_dev_addr(input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(REG_DEV_ADDR) << 2;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dev_addr = value;
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [3:0] ra, input logic [7:0] val,
                         input logic [4:0] cnt, input logic sda, input sda_pat_e pat,
                         input logic finish, input logic fixed, input out_word_t want);
    dir_row_t row;
    row.w      = '{command: cmd, reg_address: ra, write_value: val, read_count: cnt,
                   sda_in: sda};
    row.pat    = pat;
    row.finish = finish;
    row.fixed  = fixed;
    row.want   = want;
    dir_rows.push_back(row);
  endtask

  // Random register transactions, mostly well formed, with noise
  task automatic random_phase(input int n_items, input logic do_hold);
    in_word_t w;
    int       sent;
    int       r;
    sent = 0;
    while (sent < n_items || ph != PH_IDLE) begin
      w = in_word_t'($urandom);
      r = $urandom_range(99);
      if (ph == PH_IDLE) begin
        if (r < 80) begin
          w.command = (r < 36) ? CMD_WRITE : CMD_READ;
          // mostly short bursts, now and then any count at all
          if ($urandom_range(19) != 0) w.read_count = 5'($urandom_range(3, 1));
          sent++;
        end else begin
          w.command = (r < 90) ? CMD_TICK : CMD_UNUSED;
        end
      end else begin
        w.command = (r < 2) ? CMD_WRITE : (r < 4) ? CMD_READ :
                    (r < 6) ? CMD_UNUSED : CMD_TICK;
        sent++;
      end
      // hold the receiver off in the middle of the first transaction
      if (do_hold && sent == 20) hold_req <= 1'b1;
      send_word(w, 1'b0, '0);
    end
  endtask

  // Receiver: one long hold-off on request, otherwise random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= (hold_left > 1);
    end else if (hold_req && !hold_taken) begin
      hold_left   <= HOLD_CYCLES;
      hold_taken  <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_words_due.size() == 0) begin
        $error("result word with nothing expected: %0h", out_data_o);
        mismatches++;
      end else begin
        due_word = bus_words_due.pop_front();
        check_field("scl_level", 8'(due_word.scl_level), 8'(out_data_o.scl_level));
        check_field("sda_pull_low", 8'(due_word.sda_pull_low), 8'(out_data_o.sda_pull_low));
        check_field("read_byte", due_word.read_byte, out_data_o.read_byte);
        check_field("byte_valid", 8'(due_word.byte_valid), 8'(out_data_o.byte_valid));
        check_field("busy_res", 8'(due_word.busy_res), 8'(out_data_o.busy_res));
        check_field("done_res", 8'(due_word.done_res), 8'(out_data_o.done_res));
      end
    end
  end

  // Watchdog on cycles where neither side moves a word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_i2c_register_access_master_core: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    dev_addr = DEV_ADDR_RESET;
    ph   = PH_IDLE;
    bidx = '0;
    shreg = '0;
    left = '0;
    lcmd = '0;
    lreg = '0;
    lval = '0;
    stg  = STG_WADDR;

    // Directed table: idle ticks, the unused command, extremes of every field,
    // zero and oversized read counts, commands arriving while busy
    add_row(CMD_TICK,   4'h0, 8'h00, 5'd0,  1'b0, SDA_LOW,    1'b0, 1'b1, IDLE_WORD);
    add_row(CMD_TICK,   4'hF, 8'hFF, 5'd31, 1'b1, SDA_LOW,    1'b0, 1'b1, IDLE_WORD);
    add_row(CMD_UNUSED, 4'hF, 8'hFF, 5'd31, 1'b1, SDA_LOW,    1'b0, 1'b1, IDLE_WORD);
    add_row(CMD_WRITE,  4'h0, 8'h00, 5'd0,  1'b0, SDA_LOW,    1'b1, 1'b1, START_WORD);
    add_row(CMD_WRITE,  4'hF, 8'hFF, 5'd31, 1'b1, SDA_HIGH,   1'b1, 1'b1, START_WORD);
    add_row(CMD_READ,   4'h0, 8'h00, 5'd0,  1'b0, SDA_HIGH,   1'b1, 1'b1, START_WORD);
    add_row(CMD_READ,   4'hF, 8'hFF, 5'd31, 1'b1, SDA_LOW,    1'b1, 1'b1, START_WORD);
    add_row(CMD_READ,   4'h5, 8'h3C, 5'd3,  1'b0, SDA_TOGGLE, 1'b1, 1'b0, '0);
    add_row(CMD_READ,   4'hA, 8'h00, 5'd1,  1'b1, SDA_RANDOM, 1'b1, 1'b0, '0);
    add_row(CMD_WRITE,  4'h3, 8'hA5, 5'd2,  1'b0, SDA_LOW,    1'b0, 1'b1, START_WORD);
    add_row(CMD_READ,   4'h7, 8'h5A, 5'd4,  1'b1, SDA_LOW,    1'b0, 1'b0, '0);
    add_row(CMD_WRITE,  4'h8, 8'h11, 5'd2,  1'b0, SDA_RANDOM, 1'b1, 1'b0, '0);
    add_row(CMD_READ,   4'h9, 8'h00, 5'd2,  1'b1, SDA_LOW,    1'b0, 1'b0, '0);
    add_row(CMD_UNUSED, 4'h1, 8'h01, 5'd9,  1'b0, SDA_RANDOM, 1'b1, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].want);
      if (dir_rows[i].finish) run_out(dir_rows[i].pat);
    end
    drain();

    // Random phases, each under its own device address and idling mix
    write_dev_addr(7'd0);
    random_phase(40, 1'b1);
    drain();

    write_dev_addr(7'd127);
    gap_pct = 58;
    random_phase(40, 1'b0);
    drain();

    write_dev_addr(7'($urandom));
    gap_pct = 0;
    stall_pct = 58;
    random_phase(40, 1'b0);
    drain();

    write_dev_addr(7'($urandom));
    gap_pct = 6;
    stall_pct = 6;
    random_phase(40, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("tb_i2c_register_access_master_core: PASS");
    end else begin
      $display("tb_i2c_register_access_master_core: FAIL");
    end
    $finish;
  end

endmodule
